// ===== rtl/ipv6tap_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6tap_pkg
// Shared types, character codes and helpers of the IPv6 text address parser.
// ----------------------------------------------------------------------------
package ipv6tap_pkg;

    localparam int GROUPS       = 8;
    localparam int GROUP_W      = 16;
    localparam int ADDR_HALF_W  = 64;

    localparam logic [15:0] CHAR_OPEN  = 16'h005B;
    localparam logic [15:0] CHAR_CLOSE = 16'h005D;
    localparam logic [15:0] CHAR_COLON = 16'h003A;
    localparam logic [15:0] CHAR_NUL   = 16'h0000;

    localparam logic [7:0] FIRST_BYTE_MATCH = 8'h03;
    localparam logic [7:0] FIRST_BYTE_SUBST = 8'h02;

    localparam logic [2:0] DIGITS_FULL = 3'd4;
    localparam logic [3:0] GROUPS_FULL = 4'd8;

    typedef struct packed {
        logic [GROUPS-1:0][GROUP_W-1:0] groups;
        logic [3:0]                     groups_done;
        logic [3:0]                     gap_index;
        logic                           gap_seen;
        logic [GROUP_W-1:0]             hex_accum;
        logic [2:0]                     digits;
        logic                           at_first_char;
        logic                           colon_pending;
        logic                           stopped;
        logic                           failed;
    } t_pstate;

    localparam t_pstate PSTATE_INIT = '{
        groups:        '0,
        groups_done:   4'd0,
        gap_index:     4'd0,
        gap_seen:      1'b0,
        hex_accum:     '0,
        digits:        3'd0,
        at_first_char: 1'b1,
        colon_pending: 1'b0,
        stopped:       1'b0,
        failed:        1'b0
    };

    typedef struct packed {
        logic                   ok;
        logic [ADDR_HALF_W-1:0] addr_high;
        logic [ADDR_HALF_W-1:0] addr_low;
    } t_result;

    // {valid, nibble}
    function automatic logic [4:0] hex_value(input logic [15:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 16'h0030 && c <= 16'h0039) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 16'h0061 && c <= 16'h0066) ||
                     (c >= 16'h0041 && c <= 16'h0046)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

endpackage

// ===== rtl/ipv6tap_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6tap_if
// Valid/ready channels of the parser: character input and address output.
// ----------------------------------------------------------------------------
interface ipv6tap_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_code;
    logic        last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface ipv6tap_addr_if;
    logic        valid;
    logic        ready;
    logic        ok;
    logic [63:0] addr_high;
    logic [63:0] addr_low;

    modport source (output valid, output ok, output addr_high, output addr_low, input ready);
    modport sink   (input valid, input ok, input addr_high, input addr_low, output ready);
endinterface

// ===== rtl/ipv6tap_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6tap_core
// Per-character parse step and end-of-string address assembly.
// ----------------------------------------------------------------------------
module ipv6tap_core
    import ipv6tap_pkg::*;
(
    input  logic [15:0] i_char_code,
    input  logic        i_last_char,
    input  t_pstate     i_state,
    output t_pstate     o_state,
    output t_result     o_result
);

    function automatic t_pstate f_store(input t_pstate s);
        t_pstate r;
        r = s;
        r.groups[s.groups_done[2:0]] = s.hex_accum;
        r.groups_done = 4'(s.groups_done + 4'd1);
        r.hex_accum   = '0;
        r.digits      = 3'd0;
        if (r.groups_done >= GROUPS_FULL) begin
            r.stopped = 1'b1;
        end
        return r;
    endfunction

    t_pstate s_step;
    t_pstate s_end;

    always_comb begin
        t_pstate    s;
        logic       is_stop;
        logic       is_colon;
        logic       skip;
        logic       take;
        logic       do_digit;
        logic       do_store;
        logic       from_digit;
        logic [4:0] hv;

        s          = i_state;
        is_stop    = (i_char_code == CHAR_CLOSE) || (i_char_code == CHAR_NUL);
        is_colon   = (i_char_code == CHAR_COLON);
        hv         = hex_value(i_char_code);
        skip       = 1'b0;
        take       = 1'b0;
        do_digit   = 1'b0;
        do_store   = 1'b0;
        from_digit = 1'b0;

        if (!(s.stopped || s.failed)) begin
            if (s.at_first_char) begin
                s.at_first_char = 1'b0;
                if (i_char_code == CHAR_OPEN) skip = 1'b1;
            end
            if (!skip && s.colon_pending) begin
                s.colon_pending = 1'b0;
                if (is_colon) skip = 1'b1;
            end
            if (!skip) begin
                if (s.digits >= 3'd1 && s.digits <= 3'd3) begin
                    if (is_colon) begin
                        do_store = 1'b1;
                    end else if (is_stop) begin
                        do_store  = 1'b1;
                        s.stopped = 1'b1;
                    end else begin
                        do_digit = 1'b1;
                    end
                end else begin
                    take = 1'b1;
                    if (s.digits == DIGITS_FULL) begin
                        s.digits = 3'd0;
                        if (is_colon) take = 1'b0;
                    end
                    if (take) begin
                        if (is_stop) begin
                            s.stopped = 1'b1;
                        end else if (is_colon) begin
                            if (s.gap_seen) begin
                                s.failed = 1'b1;
                            end else begin
                                s.gap_seen  = 1'b1;
                                s.gap_index = s.groups_done;
                                if (s.groups_done == 4'd0) s.colon_pending = 1'b1;
                            end
                        end else begin
                            s.hex_accum = '0;
                            s.digits    = 3'd0;
                            do_digit    = 1'b1;
                        end
                    end
                end
            end
        end

        if (do_digit) begin
            if (!hv[4]) begin
                s.failed = 1'b1;
            end else begin
                s.hex_accum = {s.hex_accum[11:0], hv[3:0]};
                s.digits    = 3'(s.digits + 3'd1);
                if (s.digits >= DIGITS_FULL) begin
                    do_store   = 1'b1;
                    from_digit = 1'b1;
                end
            end
        end

        if (do_store) begin
            s = f_store(s);
            if (from_digit && !s.stopped) s.digits = DIGITS_FULL;
        end
        s_step = s;
    end

    always_comb begin
        s_end = s_step;
        if (!s_step.stopped && !s_step.failed &&
            s_step.digits >= 3'd1 && s_step.digits <= 3'd3) begin
            s_end = f_store(s_step);
        end
    end

    always_comb begin
        logic [3:0]  n;
        logic [3:0]  gp;
        logic [3:0]  z;
        logic [3:0]  j4;
        logic        ok;
        logic [15:0] g [GROUPS];

        n  = s_end.groups_done;
        gp = s_end.gap_seen ? ((s_end.gap_index > n) ? n : s_end.gap_index) : GROUPS_FULL;
        z  = s_end.gap_seen ? 4'(GROUPS_FULL - n) : 4'd0;
        for (int j = 0; j < GROUPS; j++) begin
            j4 = 4'(j);
            if (j4 < gp) begin
                g[j] = s_end.groups[j];
            end else if (j4 < 4'(gp + z)) begin
                g[j] = '0;
            end else begin
                g[j] = s_end.groups[3'(j4 - z)];
            end
        end
        if (g[0][15:8] == FIRST_BYTE_MATCH) g[0][15:8] = FIRST_BYTE_SUBST;

        ok = !s_end.failed && (s_end.gap_seen || s_end.groups_done == GROUPS_FULL);
        o_result.ok        = ok;
        o_result.addr_high = ok ? {g[0], g[1], g[2], g[3]} : '0;
        o_result.addr_low  = ok ? {g[4], g[5], g[6], g[7]} : '0;
    end

    assign o_state = i_last_char ? PSTATE_INIT : s_step;

endmodule

// ===== rtl/ipv6_text_address_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_address_parser
// Parses IPv6 address text, one UTF-16 character per transaction, into a
// 128-bit address with a validity flag.
// ----------------------------------------------------------------------------
// One character is taken every cycle unless a stalled result holds intake. A
// character enters an input register, is parsed against the per-string state
// as it leaves that register, and the character flagged last_char yields one
// result transaction; other characters yield none. The result sits in an
// output register, so input keeps flowing while it waits; a stalled result
// stops intake only once the input register is also occupied. Parser state
// returns to its initial value after each last character.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser
    import ipv6tap_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ipv6tap_char_if.sink          i_char,
    ipv6tap_addr_if.source        o_addr
);

    logic        r_in_valid;
    logic [15:0] r_char_code;
    logic        r_last_char;
    t_pstate     r_state;
    t_pstate     n_state;
    t_result     n_result;
    logic        r_out_valid;
    t_result     r_result;
    logic        w_advance;
    logic        w_fire;

    assign w_advance    = !r_out_valid || o_addr.ready;
    assign w_fire       = r_in_valid && w_advance;
    assign i_char.ready = !r_in_valid || w_advance;

    ipv6tap_core u_core (
        .i_char_code (r_char_code),
        .i_last_char (r_last_char),
        .i_state     (r_state),
        .o_state     (n_state),
        .o_result    (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= PSTATE_INIT;
        end else begin
            if (i_char.ready) begin
                r_in_valid <= i_char.valid;
            end
            if (w_advance) begin
                r_out_valid <= w_fire && r_last_char;
            end
            if (w_fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready) begin
            r_char_code <= i_char.char_code;
            r_last_char <= i_char.last_char;
        end
        if (w_fire && r_last_char) begin
            r_result <= n_result;
        end
    end

    assign o_addr.valid     = r_out_valid;
    assign o_addr.ok        = r_result.ok;
    assign o_addr.addr_high = r_result.addr_high;
    assign o_addr.addr_low  = r_result.addr_low;

endmodule

// ===== rtl/ipv6tap_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6tap_checker
// Port-level checks of the IPv6 text address parser.
// ----------------------------------------------------------------------------
module ipv6tap_checker
    import ipv6tap_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_out_ok,
    input logic [63:0] i_out_high,
    input logic [63:0] i_out_low
);

    // hold a stalled result transaction
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result transaction dropped while stalled");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ok |-> i_out_high == 64'd0 && i_out_low == 64'd0)
        else $error("failed parse carries a nonzero address");

    a_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ok |-> i_out_high[63:56] != FIRST_BYTE_MATCH)
        else $error("first byte not normalized");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result transaction right after reset");

endmodule

bind ipv6_text_address_parser ipv6tap_checker u_ipv6tap_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_addr.valid),
    .i_out_ready (o_addr.ready),
    .i_out_ok    (o_addr.ok),
    .i_out_high  (o_addr.addr_high),
    .i_out_low   (o_addr.addr_low)
);

// ===== bench/ipv6_text_address_parser_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_checker
// Watches the character and address channels of the parser. It keeps its own
// copy of the parse state for each accepted character and, on the last
// character of a string, queues the address that the string should give.
// Each address transaction is compared with the oldest queued address. The
// number of failures and of addresses still due go back to the testbench top.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_checker
    import ipv6tap_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    ipv6tap_char_if i_char,
    ipv6tap_addr_if i_addr,
    output int      o_mismatch_count,
    output int      o_pending_count
);

    localparam logic [15:0] CH_ZERO = 16'h0030;
    localparam logic [15:0] CH_NINE = 16'h0039;
    localparam logic [15:0] CH_LA   = 16'h0061;
    localparam logic [15:0] CH_LF   = 16'h0066;
    localparam logic [15:0] CH_UA   = 16'h0041;
    localparam logic [15:0] CH_UF   = 16'h0046;

    logic [15:0] grp [GROUPS];
    logic [3:0]  grp_count;
    logic [3:0]  gap_pos;
    logic        gap_found;
    logic [15:0] accum;
    logic [2:0]  ndigits;
    logic        first_char;
    logic        colon_pending;
    logic        halted;
    logic        broken;

    t_result     addr_queue [$];

    task automatic clear_parse();
        for (int i = 0; i < GROUPS; i++) begin
            grp[i] = '0;
        end
        grp_count     = '0;
        gap_pos       = '0;
        gap_found     = 1'b0;
        accum         = '0;
        ndigits       = '0;
        first_char    = 1'b1;
        colon_pending = 1'b0;
        halted        = 1'b0;
        broken        = 1'b0;
    endtask

    task automatic close_group();
        grp[grp_count[2:0]] = accum;
        grp_count = grp_count + 4'd1;
        accum     = '0;
        ndigits   = '0;
        if (grp_count >= GROUPS_FULL) begin
            halted = 1'b1;
        end
    endtask

    task automatic push_digit(input logic [15:0] c);
        logic [3:0] nib;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            nib = 4'(c - CH_ZERO);
        end else if (c >= CH_LA && c <= CH_LF) begin
            nib = 4'(c - CH_LA + 16'd10);
        end else if (c >= CH_UA && c <= CH_UF) begin
            nib = 4'(c - CH_UA + 16'd10);
        end else begin
            broken = 1'b1;
            return;
        end
        accum   = {accum[11:0], nib};
        ndigits = ndigits + 3'd1;
        if (ndigits >= DIGITS_FULL) begin
            close_group();
            if (!halted) begin
                ndigits = DIGITS_FULL;
            end
        end
    endtask

    task automatic take_char(input logic [15:0] c);
        logic term;
        term = (c == CHAR_CLOSE) || (c == CHAR_NUL);
        if (halted || broken) begin
            return;
        end
        if (first_char) begin
            first_char = 1'b0;
            if (c == CHAR_OPEN) begin
                return;
            end
        end
        if (colon_pending) begin
            colon_pending = 1'b0;
            if (c == CHAR_COLON) begin
                return;
            end
        end
        if (ndigits >= 3'd1 && ndigits <= 3'd3) begin
            if (c == CHAR_COLON) begin
                close_group();
            end else if (term) begin
                close_group();
                halted = 1'b1;
            end else begin
                push_digit(c);
            end
            return;
        end
        if (ndigits == DIGITS_FULL) begin
            ndigits = '0;
            if (c == CHAR_COLON) begin
                return;
            end
        end
        if (term) begin
            halted = 1'b1;
            return;
        end
        if (c == CHAR_COLON) begin
            if (gap_found) begin
                broken = 1'b1;
                return;
            end
            gap_found = 1'b1;
            gap_pos   = grp_count;
            if (grp_count == 4'd0) begin
                colon_pending = 1'b1;
            end
            return;
        end
        accum   = '0;
        ndigits = '0;
        push_digit(c);
    endtask

    function automatic t_result assemble_addr();
        logic [15:0] g [GROUPS];
        int          n;
        int          gp;
        int          z;
        t_result     r;
        for (int i = 0; i < GROUPS; i++) begin
            g[i] = grp[i];
        end
        r    = '0;
        r.ok = !broken;
        if (r.ok && gap_found) begin
            n  = (grp_count > GROUPS_FULL) ? GROUPS : int'(grp_count);
            gp = (int'(gap_pos) > n) ? n : int'(gap_pos);
            z  = GROUPS - n;
            for (int i = n - 1; i >= gp; i--) begin
                g[i + z] = g[i];
            end
            for (int i = 0; i < z; i++) begin
                g[gp + i] = '0;
            end
        end else if (r.ok && grp_count != GROUPS_FULL) begin
            r.ok = 1'b0;
        end
        if (r.ok) begin
            if (g[0][15:8] == FIRST_BYTE_MATCH) begin
                g[0][15:8] = FIRST_BYTE_SUBST;
            end
            r.addr_high = {g[0], g[1], g[2], g[3]};
            r.addr_low  = {g[4], g[5], g[6], g[7]};
        end
        return r;
    endfunction

    task automatic predict_char(input logic [15:0] c, input logic last);
        take_char(c);
        if (!last) begin
            return;
        end
        if (!halted && !broken && ndigits >= 3'd1 && ndigits <= 3'd3) begin
            close_group();
        end
        addr_queue.insert(addr_queue.size(), assemble_addr());
        clear_parse();
    endtask

    task automatic check_addr();
        t_result want;
        if (addr_queue.size() == 0) begin
            o_mismatch_count++;
            if (o_mismatch_count <= 10) begin
                $display("%0t: unexpected address: ok=%0b high=%h low=%h", $realtime,
                         i_addr.ok, i_addr.addr_high, i_addr.addr_low);
            end
            return;
        end
        want = addr_queue.pop_front();
        if (want.ok !== i_addr.ok || want.addr_high !== i_addr.addr_high ||
            want.addr_low !== i_addr.addr_low) begin
            o_mismatch_count++;
            if (o_mismatch_count <= 10) begin
                $display("%0t: address mismatch: expected ok=%0b high=%h low=%h", $realtime,
                         want.ok, want.addr_high, want.addr_low);
                $display("%0t:                   actual   ok=%0b high=%h low=%h", $realtime,
                         i_addr.ok, i_addr.addr_high, i_addr.addr_low);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
            addr_queue.delete();
            o_mismatch_count = 0;
        end else begin
            if (i_addr.valid && i_addr.ready) begin
                check_addr();
            end
            if (i_char.valid && i_char.ready) begin
                predict_char(i_char.char_code, i_char.last_char);
            end
        end
        o_pending_count = addr_queue.size();
    end

endmodule

// ===== bench/ipv6_text_address_parser_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv6_text_address_parser_tb
// Feeds the parser address strings one character at a time: a few fixed
// strings for the corner cases, then random well-formed addresses with
// brackets, gaps, dense four-digit runs and terminators, some of them
// corrupted, mixed with random junk strings. The run goes through phases of
// sender idling and receiver stalling; the checker beside the parser judges
// every address transaction.
// ----------------------------------------------------------------------------
module ipv6_text_address_parser_tb;
    import ipv6tap_pkg::*;

    localparam int PHASE_CHARS = 463;
    localparam int CYCLE_LIMIT = 400000;

    localparam logic [15:0] CH_ZERO = 16'h0030;
    localparam logic [15:0] CH_LA   = 16'h0061;
    localparam logic [15:0] CH_UA   = 16'h0041;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipv6tap_char_if char_if ();
    ipv6tap_addr_if addr_if ();

    int mismatch_count;
    int pending_count;
    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    int chars_sent  = 0;

    logic [15:0] text [$];

    ipv6_text_address_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_addr  (addr_if)
    );

    ipv6_text_address_parser_checker chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_char           (char_if),
        .i_addr           (addr_if),
        .o_mismatch_count (mismatch_count),
        .o_pending_count  (pending_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        addr_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [15:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return CH_ZERO + 16'(v);
        end
        return ($urandom_range(1) ? CH_LA : CH_UA) + 16'(v) - 16'd10;
    endfunction

    function automatic logic [15:0] junk_char();
        case ($urandom_range(5))
            0:       return 16'($urandom_range(0, 65535));
            1:       return CHAR_COLON;
            2:       return CHAR_OPEN;
            3:       return CHAR_CLOSE;
            4:       return CHAR_NUL;
            default: return hex_char(4'($urandom));
        endcase
    endfunction

    task automatic append_char(input logic [15:0] c);
        text.insert(text.size(), c);
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++) begin
            append_char({8'h00, s[i]});
        end
    endtask

    task automatic add_group(input int ndig, input logic [15:0] val);
        for (int k = ndig - 1; k >= 0; k--) begin
            append_char(hex_char(val[4*k +: 4]));
        end
    endtask

    task automatic build_address();
        int          n;
        int          gp;
        int          nd;
        int          prev_nd;
        int          idx;
        logic        gap;
        logic        bracket;
        logic        dense;
        logic [15:0] val;
        bracket = ($urandom_range(99) < 30);
        dense   = ($urandom_range(99) < 10);
        n       = $urandom_range(0, 8);
        gap     = (n < 8) ? ($urandom_range(99) < 85) : ($urandom_range(99) < 20);
        gp      = $urandom_range(0, n);
        prev_nd = 0;
        if (bracket) begin
            append_char(CHAR_OPEN);
        end
        for (int i = 0; i < n; i++) begin
            if (gap && i == gp) begin
                add_str("::");
            end else if (i > 0 && !(dense && prev_nd == 4)) begin
                append_char(CHAR_COLON);
            end
            nd = dense ? 4 : $urandom_range(1, 4);
            case ($urandom_range(9))
                0:       val = '0;
                1:       val = '1;
                default: val = 16'($urandom);
            endcase
            if (i == 0 && $urandom_range(99) < 15) begin
                val[15:8] = FIRST_BYTE_MATCH;
                nd        = $urandom_range(3, 4);
            end
            add_group(nd, val);
            prev_nd = nd;
        end
        if (gap && gp == n) begin
            add_str("::");
        end
        case ($urandom_range(3))
            0: if (bracket) append_char(CHAR_CLOSE);
            1: append_char(CHAR_NUL);
            default: ;
        endcase
        if ($urandom_range(99) < 25) begin
            repeat ($urandom_range(1, 3)) append_char(junk_char());
        end
        if (text.size() > 0 && $urandom_range(99) < 15) begin
            idx = $urandom_range(0, text.size() - 1);
            if ($urandom_range(1)) begin
                text[idx] = junk_char();
            end else begin
                text.delete(idx);
            end
        end
        if (text.size() == 0) begin
            append_char(hex_char(4'($urandom)));
        end
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 12)) append_char(junk_char());
    endtask

    task automatic send_char(input logic [15:0] c, input logic last);
        int gap;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            gap = $urandom_range(1, 4);
            char_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_code <= c;
        char_if.last_char <= last;
        @(posedge i_clk);
        while (!char_if.ready) @(posedge i_clk);
        chars_sent++;
    endtask

    task automatic send_text();
        for (int i = 0; i < text.size(); i++) begin
            send_char(text[i], i == text.size() - 1);
        end
        text.delete();
    endtask

    initial begin
        int target;
        char_if.valid     = 1'b0;
        char_if.char_code = '0;
        char_if.last_char = 1'b0;
        addr_if.ready     = 1'b0;
        i_rst_n           = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_str("::");                   send_text();
        add_str("[::1]x");               send_text();
        add_str("0300::");               send_text();
        add_str("12345");                send_text();
        add_str("FfFf:0:0:0:0:0:0:0");   send_text();
        add_str("1::2:3:4:5:6:7:8");     send_text();
        add_str("1::2::3");              send_text();
        add_str("1:2:");                 send_text();
        add_str("1[");                   send_text();
        add_str("1::");
        append_char(CHAR_NUL);
        add_str("5");                    send_text();
        add_str("ff");
        append_char(16'hFFFF);           send_text();
        add_str("[");                    send_text();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 88; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 88; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            target = chars_sent + PHASE_CHARS;
            while (chars_sent < target) begin
                if ($urandom_range(99) < 80) begin
                    build_address();
                end else begin
                    build_noise();
                end
                send_text();
            end
        end
        char_if.valid <= 1'b0;

        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
